// File: rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table insert and find unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int HASH_W          = 32;
    localparam int KEY_W           = 2 * HASH_W;
    localparam int SIZE_W          = 32;
    localparam int POS_W           = 8;
    localparam int TOTAL_W         = 9;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_FIND   = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [HASH_W-1:0] type_hash;
        logic [HASH_W-1:0] file_hash;
        logic [SIZE_W-1:0] entry_size;
    } cmd_data_t;

    typedef struct packed
    {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [SIZE_W-1:0]  found_size;
        logic [TOTAL_W-1:0] entry_total;
    } rsp_data_t;

    typedef struct packed
    {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed
    {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_HIT,
        S_EVAL,
        S_SHIFT,
        S_WRITE,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/skt_store.sv
// ----------------------------------------------------------------------------
// skt_store
// Entry memory: key and size per slot, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_store #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic             clk,
    input  wire skt_pkg::mem_ctl_t mem_ctl,
    input  wire logic [IDX_W-1:0] rd_addr,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire skt_pkg::entry_t  wr_entry,
    output skt_pkg::entry_t       rd_entry
);

    skt_pkg::entry_t mem [TABLE_DEPTH];
    skt_pkg::entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (mem_ctl.rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

// File: rtl/core/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: binary search, hit check, shift-up of later entries and insert.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire skt_pkg::cmd_data_t cmd_data,
    output logic                    cmd_stall,
    output skt_pkg::mem_ctl_t       mem_ctl,
    output logic [IDX_W-1:0]        rd_addr,
    output logic [IDX_W-1:0]        wr_addr,
    output skt_pkg::entry_t         wr_entry,
    input  wire skt_pkg::entry_t    rd_entry,
    input  wire logic               rsp_free,
    output logic                    rsp_load,
    output skt_pkg::rsp_data_t      rsp
);

    skt_pkg::state_t state_reg, state_next;

    skt_pkg::cmd_t                cmd_reg, cmd_next;
    logic [skt_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [skt_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             lo_reg, lo_next;
    logic [CNT_W-1:0]             hi_reg, hi_next;
    logic [CNT_W-1:0]             j_reg, j_next;
    logic                         pend_reg, pend_next;
    logic                         hit_reg, hit_next;
    skt_pkg::status_t             status_reg, status_next;
    logic [skt_pkg::SIZE_W-1:0]   fsize_reg, fsize_next;
    logic [CNT_W-1:0]             pos_reg, pos_next;

    logic [CNT_W-1:0] mid;
    logic             full;
    logic             cmd_acc;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign cmd_acc = cmd_valid && (state_reg == skt_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (cmd_acc)
                begin
                    state_next = skt_pkg::S_SRCH;
                end
            end
            skt_pkg::S_SRCH:
            begin
                priority if (lo_reg < hi_reg)
                begin
                    state_next = skt_pkg::S_CMP;
                end
                else if (lo_reg < count_reg)
                begin
                    state_next = skt_pkg::S_HIT;
                end
                else
                begin
                    state_next = skt_pkg::S_EVAL;
                end
            end
            skt_pkg::S_CMP:   state_next = skt_pkg::S_SRCH;
            skt_pkg::S_HIT:   state_next = skt_pkg::S_EVAL;
            skt_pkg::S_EVAL:
            begin
                if (cmd_reg == skt_pkg::CMD_INSERT && !hit_reg && !full)
                begin
                    state_next = skt_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = skt_pkg::S_RESP;
                end
            end
            skt_pkg::S_SHIFT:
            begin
                if (j_reg == lo_reg && !pend_reg)
                begin
                    state_next = skt_pkg::S_WRITE;
                end
            end
            skt_pkg::S_WRITE: state_next = skt_pkg::S_RESP;
            skt_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default:          state_next = skt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        mem_ctl   = '0;
        rd_addr   = IDX_W'(mid);
        wr_addr   = IDX_W'(j_reg + 1'b1);
        wr_entry  = rd_entry;
        rsp_load  = 1'b0;
        cmd_stall = (state_reg != skt_pkg::S_IDLE);
        unique case (state_reg)
            skt_pkg::S_SRCH:
            begin
                mem_ctl.rd_en = (lo_reg < hi_reg) || (lo_reg < count_reg);
                rd_addr       = (lo_reg < hi_reg) ? IDX_W'(mid) : IDX_W'(lo_reg);
            end
            skt_pkg::S_SHIFT:
            begin
                mem_ctl.rd_en = (j_reg > lo_reg);
                rd_addr       = IDX_W'(j_reg - 1'b1);
                mem_ctl.wr_en = pend_reg;
            end
            skt_pkg::S_WRITE:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = IDX_W'(lo_reg);
                wr_entry.key  = key_reg;
                wr_entry.size = size_reg;
            end
            skt_pkg::S_RESP:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        size_next   = size_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        j_next      = j_reg;
        pend_next   = pend_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        fsize_next  = fsize_reg;
        pos_next    = pos_reg;
        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (cmd_acc)
                begin
                    cmd_next  = cmd_data.cmd;
                    key_next  = {cmd_data.file_hash, cmd_data.type_hash};
                    size_next = cmd_data.entry_size;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    hit_next  = 1'b0;
                end
            end
            skt_pkg::S_CMP:
            begin
                if (rd_entry.key < key_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            skt_pkg::S_HIT:
            begin
                hit_next   = (rd_entry.key == key_reg);
                fsize_next = rd_entry.size;
            end
            skt_pkg::S_EVAL:
            begin
                j_next    = count_reg;
                pend_next = 1'b0;
                priority if (cmd_reg == skt_pkg::CMD_FIND)
                begin
                    status_next = hit_reg ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
                    pos_next    = hit_reg ? lo_reg : '0;
                    fsize_next  = hit_reg ? fsize_reg : '0;
                end
                else if (hit_reg)
                begin
                    status_next = skt_pkg::ST_DUP;
                    pos_next    = lo_reg;
                    fsize_next  = '0;
                end
                else if (full)
                begin
                    status_next = skt_pkg::ST_FULL;
                    pos_next    = '0;
                    fsize_next  = '0;
                end
                else
                begin
                    status_next = skt_pkg::ST_OK;
                    pos_next    = lo_reg;
                    fsize_next  = '0;
                end
            end
            skt_pkg::S_SHIFT:
            begin
                pend_next = (j_reg > lo_reg);
                if (j_reg > lo_reg)
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            skt_pkg::S_WRITE:
            begin
                count_next = count_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        size_reg   <= size_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        j_reg      <= j_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        fsize_reg  <= fsize_next;
        pos_reg    <= pos_next;
    end

    assign rsp.status      = status_reg;
    assign rsp.position    = skt_pkg::POS_W'(pos_reg);
    assign rsp.found_size  = fsize_reg;
    assign rsp.entry_total = skt_pkg::TOTAL_W'(count_reg);

endmodule

`default_nettype wire

// File: rtl/core/sorted_key_table_insert_find_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_find_unit
// Sorted table of {file_hash, type_hash} keys with size payloads; insert and
// find by binary search over a single-port-read entry memory.
// ----------------------------------------------------------------------------
// One transaction at a time. A find runs a binary search over the n entries
// held: every search step is a memory read followed by a compare, since the
// entry memory has one registered read port, plus one read to check the hit
// when the search ends below the entry count. A successful insert then moves
// the later entries up one slot, pipelined read and write at one entry per
// cycle, and writes the new entry. A new command is taken while the previous
// result still waits on rsp_stall. The memory has no reset; only slots below
// the entry count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_insert_find_unit #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire skt_pkg::cmd_data_t cmd_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output skt_pkg::rsp_data_t      rsp_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    skt_pkg::mem_ctl_t  mem_ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    skt_pkg::entry_t    wr_entry;
    skt_pkg::entry_t    rd_entry;
    logic               rsp_free;
    logic               rsp_load;
    skt_pkg::rsp_data_t rsp;

    logic               rsp_valid_reg;
    skt_pkg::rsp_data_t rsp_data_reg;

    skt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_stall (cmd_stall),
        .mem_ctl   (mem_ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry),
        .rd_entry  (rd_entry),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp       (rsp)
    );

    skt_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk      (clk),
        .mem_ctl  (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry)
    );

    // result holding register
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_data_reg <= rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire
